// ===== rtl/core/gws_pkg.sv =====
// Package for the eight-direction grid word search block.
// Holds sizes, the request and result types, and the direction tables.
// No dependencies.
package gws_pkg;

    localparam int MAX_DIM      = 64;
    localparam int MAX_WORD     = 64;
    localparam int MAX_MATCHES  = 63;
    localparam int DIM_W        = $clog2(MAX_DIM);
    localparam int WORD_W       = $clog2(MAX_WORD);
    localparam int VISIT_W      = 20;
    localparam int MATCH_W      = 6;
    localparam logic [VISIT_W-1:0] VISIT_MAX = {VISIT_W{1'b1}};

    localparam logic REQ_CELL = 1'b0;
    localparam logic REQ_WORD = 1'b1;
    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_DONE = 1'b1;
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // one queued command from front to back
    typedef struct packed {
        logic             is_word;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [7:0]       char_code;
        logic             word_end;
    } cmd_t;

    typedef struct packed {
        logic                item_kind;
        logic [5:0]          hit_row;
        logic [5:0]          hit_col;
        logic [2:0]          direction;
        logic [VISIT_W-1:0]  visit_count;
        logic                dropped;
        logic                last_item;
    } res_t;

    // row and column step per direction: 0 none, 1 plus, 2 minus
    function automatic logic [1:0] dir_dr(input logic [2:0] d);
        case (d)
            3'd0, 3'd2, 3'd7: dir_dr = 2'd1;
            3'd4, 3'd5, 3'd6: dir_dr = 2'd2;
            default:          dir_dr = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] dir_dc(input logic [2:0] d);
        case (d)
            3'd1, 3'd2, 3'd5: dir_dc = 2'd1;
            3'd3, 3'd6, 3'd7: dir_dc = 2'd2;
            default:          dir_dc = 2'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/gws_front.sv =====
// Front end: accepts input items and config writes, pushes commands to a queue.
// Depends on gws_pkg.
module gws_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,
    input  logic          s_tuser,
    input  logic          s_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [0:0]    cfg_index,
    input  logic [6:0]    cfg_data,
    output logic [6:0]    rows_eff,
    output logic [6:0]    cols_eff,
    output gws_pkg::cmd_t q_data,
    output logic          q_valid,
    input  logic          q_ready
);
    import gws_pkg::*;

    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    logic [6:0] rows_reg, cols_reg;
    cmd_t       q_mem [QD];
    logic [QA-1:0] wp_reg, rp_reg;
    logic [QA:0]   cnt_reg;
    logic          push, pop;
    cmd_t          in_cmd;

    assign cfg_ready = 1'b1;
    assign s_tready  = (cnt_reg != (QA+1)'(QD));
    assign push      = s_tvalid && s_tready;
    assign pop       = q_valid && q_ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_data    = q_mem[rp_reg];

    // clamp sizes above the grid limit
    assign rows_eff = (rows_reg > 7'(MAX_DIM)) ? 7'(MAX_DIM) : rows_reg;
    assign cols_eff = (cols_reg > 7'(MAX_DIM)) ? 7'(MAX_DIM) : cols_reg;

    always_comb begin
        in_cmd.is_word   = s_tuser;
        in_cmd.row       = s_tdata[DIM_W-1:0];
        in_cmd.col       = s_tdata[6 +: DIM_W];
        in_cmd.char_code = s_tdata[19:12];
        in_cmd.word_end  = s_tlast;
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= 7'd22;
            cols_reg <= 7'd22;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ROWS) rows_reg <= cfg_data;
            else                       cols_reg <= cfg_data;
        end
    end

    // command queue
    always_ff @(posedge aclk) begin
        if (push) q_mem[wp_reg] <= in_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + QA'(1);
            if (pop)  rp_reg <= rp_reg + QA'(1);
            cnt_reg <= cnt_reg + (QA+1)'(push) - (QA+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/gws_back.sv =====
// Back end: grid and word memories, scan sequencer and result register.
// Depends on gws_pkg.
module gws_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  gws_pkg::cmd_t q_data,
    input  logic          q_valid,
    output logic          q_ready,
    input  logic [6:0]    rows_eff,
    input  logic [6:0]    cols_eff,
    output logic          m_tvalid,
    input  logic          m_tready,
    output gws_pkg::res_t m_res
);
    import gws_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_DIR   = 6'b000100,
        ST_CHAR  = 6'b001000,
        ST_NEXT  = 6'b010000,
        ST_DONE  = 6'b100000
    } st_t;

    localparam int GA = 2 * DIM_W;

    logic [7:0] grid_mem [MAX_DIM*MAX_DIM];
    logic [7:0] word_mem [MAX_WORD];
    logic [7:0] grid_q, word_q;

    st_t st_reg, st_next;
    logic [WORD_W:0]    len_reg;
    logic [VISIT_W-1:0] visit_reg;
    logic [DIM_W:0]     r_reg, c_reg;
    logic [2:0]         d_reg;
    logic [WORD_W:0]    k_reg;
    logic signed [DIM_W+1:0] pr_reg, pc_reg;
    logic [MATCH_W-1:0] n_reg;
    logic               drop_reg;
    logic               wait_reg;
    logic               out_v_reg;
    res_t               out_reg;

    logic grid_we, word_we;
    logic [GA-1:0]      g_raddr;
    logic [WORD_W-1:0]  w_raddr;
    logic signed [DIM_W+1:0] dr, dc, er, ec;
    logic               fits;
    logic               last_cell;

    assign m_tvalid = out_v_reg;
    assign m_res    = out_reg;
    // only a word end has to wait for the result register to drain
    assign q_ready  = (st_reg == ST_IDLE) &&
                      !(out_v_reg && q_data.is_word && q_data.word_end);

    // write side of both memories
    assign grid_we = q_valid && q_ready && !q_data.is_word;
    assign word_we = q_valid && q_ready && q_data.is_word && (len_reg < (WORD_W+1)'(MAX_WORD));

    always_ff @(posedge aclk) begin
        if (grid_we) grid_mem[{q_data.row, q_data.col}] <= q_data.char_code;
        if (word_we) word_mem[len_reg[WORD_W-1:0]] <= q_data.char_code;
    end

    // read side, registered
    always_ff @(posedge aclk) begin
        grid_q <= grid_mem[g_raddr];
        word_q <= word_mem[w_raddr];
    end

    always_comb begin
        dr = $signed({{DIM_W{1'b0}}, dir_dr(d_reg)}) ;
        dc = $signed({{DIM_W{1'b0}}, dir_dc(d_reg)}) ;
        if (dir_dr(d_reg) == 2'd2) dr = -(DIM_W+2)'(1);
        if (dir_dc(d_reg) == 2'd2) dc = -(DIM_W+2)'(1);
    end

    // endpoint of the word in direction d from (r,c); len - 1 steps
    always_comb begin
        logic signed [DIM_W+1:0] lm;
        lm = $signed((DIM_W+2)'(len_reg)) - (DIM_W+2)'(1);
        er = $signed({1'b0, r_reg}) + ((dr == 0) ? '0 : ((dr > 0) ? lm : -lm));
        ec = $signed({1'b0, c_reg}) + ((dc == 0) ? '0 : ((dc > 0) ? lm : -lm));
        fits = (er >= 0) && (er < $signed({1'b0, rows_eff})) &&
               (ec >= 0) && (ec < $signed({1'b0, cols_eff}));
    end

    // read addresses for the step being set up
    always_comb begin
        g_raddr = {pr_reg[DIM_W-1:0], pc_reg[DIM_W-1:0]};
        w_raddr = k_reg[WORD_W-1:0];
    end

    assign last_cell = (c_reg + (DIM_W+1)'(1) >= cols_eff[DIM_W:0]) &&
                       (r_reg + (DIM_W+1)'(1) >= rows_eff[DIM_W:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            len_reg   <= '0;
            visit_reg <= '0;
            out_v_reg <= 1'b0;
            wait_reg  <= 1'b0;
        end else begin
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    if (q_valid && q_ready && q_data.is_word) begin
                        if (word_we) len_reg <= len_reg + (WORD_W+1)'(1);
                        if (q_data.word_end) begin
                            r_reg    <= '0;
                            c_reg    <= '0;
                            n_reg    <= '0;
                            drop_reg <= 1'b0;
                            if (rows_eff == 7'd0 || cols_eff == 7'd0) begin
                                st_reg <= ST_DONE;
                            end else begin
                                st_reg <= ST_START;
                            end
                        end
                    end
                end
                // visit a start cell: count and fetch its char and word[0]
                ST_START: begin
                    if (visit_reg != VISIT_MAX) visit_reg <= visit_reg + VISIT_W'(1);
                    pr_reg   <= $signed({1'b0, r_reg});
                    pc_reg   <= $signed({1'b0, c_reg});
                    k_reg    <= '0;
                    d_reg    <= '0;
                    wait_reg <= 1'b1;
                    st_reg   <= ST_CHAR;
                end
                // try a direction: bounds test, then walk the chars
                ST_DIR: begin
                    if (fits) begin
                        pr_reg   <= $signed({1'b0, r_reg});
                        pc_reg   <= $signed({1'b0, c_reg});
                        k_reg    <= '0;
                        wait_reg <= 1'b1;
                        st_reg   <= ST_CHAR;
                    end else if (d_reg == 3'd7) begin
                        st_reg <= ST_NEXT;
                    end else begin
                        d_reg <= d_reg + 3'd1;
                    end
                end
                // compare one char at a time (address, then data)
                ST_CHAR: begin
                    if (wait_reg) begin
                        wait_reg <= 1'b0;
                    end else if (grid_q != word_q) begin
                        // a first-letter miss, or a miss in the last direction, skips the cell
                        if (k_reg == '0 || d_reg == 3'd7) st_reg <= ST_NEXT;
                        else begin
                            d_reg  <= d_reg + 3'd1;
                            st_reg <= ST_DIR;
                        end
                    end else if (k_reg + (WORD_W+1)'(1) >= len_reg) begin
                        // full match: report it, or flag it as dropped past the cap
                        if (n_reg != MATCH_W'(MAX_MATCHES)) begin
                            out_reg.item_kind   <= KIND_HIT;
                            out_reg.hit_row     <= 6'(r_reg);
                            out_reg.hit_col     <= 6'(c_reg);
                            out_reg.direction   <= d_reg;
                            out_reg.visit_count <= visit_reg;
                            out_reg.dropped     <= 1'b0;
                            out_reg.last_item   <= 1'b0;
                            out_v_reg           <= 1'b1;
                            n_reg <= n_reg + MATCH_W'(1);
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        visit_reg <= '0;
                        st_reg    <= ST_NEXT;
                    end else if (k_reg == '0) begin
                        // first letter matches: step along d, or try the next one
                        pr_reg   <= pr_reg + dr;
                        pc_reg   <= pc_reg + dc;
                        k_reg    <= (WORD_W+1)'(1);
                        wait_reg <= 1'b1;
                        st_reg   <= (fits) ? ST_CHAR : ST_DIR;
                    end else begin
                        pr_reg   <= pr_reg + dr;
                        pc_reg   <= pc_reg + dc;
                        k_reg    <= k_reg + (WORD_W+1)'(1);
                        wait_reg <= 1'b1;
                    end
                end
                // advance start cell, waiting for the result slot
                ST_NEXT: begin
                    if (!out_v_reg || m_tready) begin
                        if (last_cell) st_reg <= ST_DONE;
                        else begin
                            st_reg <= ST_START;
                            if (c_reg + (DIM_W+1)'(1) >= cols_eff[DIM_W:0]) begin
                                c_reg <= '0;
                                r_reg <= r_reg + (DIM_W+1)'(1);
                            end else begin
                                c_reg <= c_reg + (DIM_W+1)'(1);
                            end
                        end
                    end
                end
                // load the done item once the result register is empty
                ST_DONE: begin
                    if (!out_v_reg) begin
                        out_reg.item_kind   <= KIND_DONE;
                        out_reg.hit_row     <= '0;
                        out_reg.hit_col     <= '0;
                        out_reg.direction   <= '0;
                        out_reg.visit_count <= visit_reg;
                        out_reg.dropped     <= drop_reg;
                        out_reg.last_item   <= 1'b1;
                        out_v_reg           <= 1'b1;
                        len_reg             <= '0;
                        st_reg              <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/grid_word_search_8dir.sv =====
// Top level of the eight-direction grid word search.
// Instantiates gws_front and gws_back; depends on gws_pkg.
//
//  channel | dir | handshake              | content
//  s_      | in  | s_tvalid / s_tready    | grid cell write or word character
//  cfg_    | in  | cfg_valid / cfg_ready  | grid_rows (0), grid_cols (1)
//  m_      | out | m_tvalid / m_tready    | match items, then one done item
//
// Cell writes and word characters are taken from the queue only in the idle state.
// A word end runs a scan of rows*cols start cells: ST_START counts a cell,
// ST_CHAR compares its first letter, and a hit walks the characters of each
// fitting direction (ST_DIR). The done item follows once the result slot is free.
// Reset (aresetn low, synchronous) clears the queue, counters and sizes (22).
// Input stalls when the four-entry queue fills: during a scan, or while a word
// end waits behind an unaccepted result.
module grid_word_search_8dir (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cell_row[5:0], cell_col[11:6], char_code[19:12]
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // word_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // hit_row[5:0], hit_col[11:6], direction[14:12],
                                   // visit_count[34:15], dropped[35]
    output logic        m_tuser,   // item_kind
    output logic        m_tlast    // last_item
);
    import gws_pkg::*;

    cmd_t       q_data;
    logic       q_valid, q_ready;
    logic [6:0] rows_eff, cols_eff;
    res_t       res;

    gws_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .rows_eff, .cols_eff, .q_data, .q_valid, .q_ready
    );

    gws_back u_back (
        .aclk, .aresetn, .q_data, .q_valid, .q_ready, .rows_eff, .cols_eff,
        .m_tvalid, .m_tready, .m_res(res)
    );

    assign m_tdata = {4'd0, res.dropped, res.visit_count, res.direction,
                      res.hit_col, res.hit_row};
    assign m_tuser = res.item_kind;
    assign m_tlast = res.last_item;

endmodule
